FILE: hdl/dmb_pkg.sv
// ----------------------------------------------------------------------------
// dmb_pkg
// constants and elaboration-time helpers for the depth mist blend pipeline
// ----------------------------------------------------------------------------
package dmb_pkg;

	localparam logic [2:0] CFG_MIST_RED      = 3'd0;
	localparam logic [2:0] CFG_MIST_GREEN    = 3'd1;
	localparam logic [2:0] CFG_MIST_BLUE     = 3'd2;
	localparam logic [2:0] CFG_MIST_AMOUNT   = 3'd3;
	localparam logic [2:0] CFG_START_DEPTH   = 3'd4;
	localparam logic [2:0] CFG_INVERSE_RANGE = 3'd5;
	localparam logic [2:0] CFG_EXCLUDE_BG    = 3'd6;

	localparam logic [63:0] ONE32      = 64'd1 << 32;
	localparam logic [24:0] ONE24      = 25'h100_0000;
	localparam logic [16:0] AMOUNT_ONE = 17'd65536;
	localparam logic [31:0] MIST_RESET = 32'd65536;
	localparam logic [63:0] P_LIMIT    = ((64'd16 << 40) + 64'd2) / 64'd3;

	// q0.32 product, rounded half up, one passes through
	function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] prod;
		prod = (a * b) + (ONE32 >> 1);
		if (a >= ONE32) begin
			return b;
		end
		if (b >= ONE32) begin
			return a;
		end
		return prod >> 32;
	endfunction

	// exp(-f), f in q0.32 below one, twenty truncated taylor terms
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = ONE32;
		term = ONE32;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * f) >> 32) / 64'(k);
			if ((k % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	localparam logic [63:0] E_HALF = exp_neg_frac(ONE32 >> 1);
	localparam logic [63:0] E_ONE  = q32_mul(E_HALF, E_HALF);

	// exp(-1)^n * exp(-r), rounded to q0.24
	function automatic logic [24:0] rom_entry(input logic [4:0] n, input logic [63:0] r);
		logic [63:0] acc;
		logic [63:0] rnd;
		acc = ONE32;
		for (int i = 0; i < int'(n); i++) begin
			acc = q32_mul(acc, E_ONE);
		end
		acc = q32_mul(acc, exp_neg_frac(r));
		rnd = (acc + 64'd128) >> 8;
		return rnd[24:0];
	endfunction

endpackage

FILE: hdl/depth_mist_blend.sv
// ----------------------------------------------------------------------------
// depth_mist_blend
// Exponential depth mist. Each pixel is blended toward the mist colour with
// weight amount * (1 - exp(-3 * (depth - start) * inverse_range)); pixels
// without mask_set, pixels at or nearer than start and excluded background
// pass unchanged. One pixel per clock when the output is not stalled. The
// exp curve is a constant table of EXP_TABLE_ENTRIES + 1 entries, built at
// elaboration and split into even and odd banks so both interpolation
// neighbors come out of one registered read; it needs no fill after reset.
// The output register and every stage hold under stall, and empty stages
// still take new pixels while a result waits.
// ----------------------------------------------------------------------------
module depth_mist_blend
	import dmb_pkg::*;
#(
	parameter int EXP_TABLE_ENTRIES = 1024,
	parameter int CHANNEL_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [2:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [8+CHANNEL_FRAC_BITS-1:0] pixel_red,
	input  logic [8+CHANNEL_FRAC_BITS-1:0] pixel_green,
	input  logic [8+CHANNEL_FRAC_BITS-1:0] pixel_blue,
	input  logic [31:0]                    depth,
	input  logic                           depth_infinite,
	input  logic                           mask_set,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [8+CHANNEL_FRAC_BITS-1:0] out_red,
	output logic [8+CHANNEL_FRAC_BITS-1:0] out_green,
	output logic [8+CHANNEL_FRAC_BITS-1:0] out_blue
);

	localparam int CW   = 8 + CHANNEL_FRAC_BITS;
	localparam int LOGN = $clog2(EXP_TABLE_ENTRIES);
	localparam int IW   = LOGN;
	localparam int PW   = LOGN + 46;
	localparam int IFW  = PW - 44;
	localparam int NE   = EXP_TABLE_ENTRIES / 2 + 1;
	localparam int NO   = (EXP_TABLE_ENTRIES + 1) / 2;
	localparam int EAW  = $clog2(NE);
	localparam int OAW  = $clog2(NO);
	localparam int PRW  = CW + 17;

	// configuration
	logic [CW-1:0] mist_red_q;
	logic [CW-1:0] mist_green_q;
	logic [CW-1:0] mist_blue_q;
	logic [16:0]   mist_amount_q;
	logic [31:0]   start_depth_q;
	logic [31:0]   inverse_range_q;
	logic          exclude_background_q;
	logic [31:0]   cfg_mist;
	logic [16:0]   amt;

	assign cfg_mist = {8'd0, cfg_data[23:0]};
	assign amt      = (mist_amount_q > AMOUNT_ONE) ? AMOUNT_ONE : mist_amount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mist_red_q           <= MIST_RESET[CW-1:0];
			mist_green_q         <= MIST_RESET[CW-1:0];
			mist_blue_q          <= MIST_RESET[CW-1:0];
			mist_amount_q        <= AMOUNT_ONE;
			start_depth_q        <= 32'd0;
			inverse_range_q      <= 32'd16777;
			exclude_background_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MIST_RED:      mist_red_q           <= cfg_mist[CW-1:0];
				CFG_MIST_GREEN:    mist_green_q         <= cfg_mist[CW-1:0];
				CFG_MIST_BLUE:     mist_blue_q          <= cfg_mist[CW-1:0];
				CFG_MIST_AMOUNT:   mist_amount_q        <= cfg_data[16:0];
				CFG_START_DEPTH:   start_depth_q        <= cfg_data;
				CFG_INVERSE_RANGE: inverse_range_q      <= cfg_data;
				CFG_EXCLUDE_BG:    exclude_background_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// exp table, even and odd banks
	logic [24:0] rom_even [NE];
	logic [24:0] rom_odd  [NO];

	for (genvar j = 0; j < NE; j++) begin : g_even
		localparam longint unsigned NUM = 64'(32 * j);
		localparam longint unsigned NI  = NUM / EXP_TABLE_ENTRIES;
		localparam longint unsigned REM = NUM % EXP_TABLE_ENTRIES;
		localparam longint unsigned RF  = (REM << 32) / EXP_TABLE_ENTRIES;
		localparam logic [24:0] VAL = rom_entry(5'(NI), 64'(RF));
		assign rom_even[j] = VAL;
	end

	for (genvar j = 0; j < NO; j++) begin : g_odd
		localparam longint unsigned NUM = 64'(32 * j + 16);
		localparam longint unsigned NI  = NUM / EXP_TABLE_ENTRIES;
		localparam longint unsigned REM = NUM % EXP_TABLE_ENTRIES;
		localparam longint unsigned RF  = (REM << 32) / EXP_TABLE_ENTRIES;
		localparam logic [24:0] VAL = rom_entry(5'(NI), 64'(RF));
		assign rom_odd[j] = VAL;
	end

	// stage flow control
	logic [9:1] vld;
	logic [9:1] vin;
	logic [9:1] en;

	assign vin = {vld[8:1], in_valid};

	always_comb begin
		en[9] = !vld[9] || !out_stall;
		for (int i = 8; i >= 1; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld[9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int i = 1; i <= 9; i++) begin
				if (en[i]) begin
					vld[i] <= vin[i];
				end
			end
		end
	end

	// pixel carried down to the blend
	logic [CW-1:0] red_s1, red_s2, red_s3, red_s4, red_s5, red_s6, red_s7;
	logic [CW-1:0] grn_s1, grn_s2, grn_s3, grn_s4, grn_s5, grn_s6, grn_s7;
	logic [CW-1:0] blu_s1, blu_s2, blu_s3, blu_s4, blu_s5, blu_s6, blu_s7;
	logic          apply_s1, apply_s2, apply_s3, apply_s4, apply_s5, apply_s6;
	logic          tamt_s1, tamt_s2, tamt_s3, tamt_s4, tamt_s5, tamt_s6;

	// stage 1: depth offset and path select
	logic [31:0] diff_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			red_s1   <= pixel_red;
			grn_s1   <= pixel_green;
			blu_s1   <= pixel_blue;
			diff_s1  <= depth - start_depth_q;
			tamt_s1  <= depth_infinite;
			apply_s1 <= mask_set && (depth_infinite ? !exclude_background_q
				: (depth > start_depth_q));
		end
	end

	// stage 2: distance times inverse range
	logic [63:0] p_mul;
	logic [63:0] p_s2;

	assign p_mul = diff_s1 * inverse_range_q;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			red_s2   <= red_s1;
			grn_s2   <= grn_s1;
			blu_s2   <= blu_s1;
			tamt_s2  <= tamt_s1;
			apply_s2 <= apply_s1;
			p_s2     <= p_mul;
		end
	end

	// stage 3: table position
	logic [PW-1:0]  pos;
	logic [IFW-1:0] idx_full;
	logic [IW-1:0]  idx_c;
	logic [15:0]    frac_c;
	logic [IW:0]    idx_p1;
	logic [IW-1:0]  ea_full;
	logic [IW-1:0]  oa_full;
	logic [EAW-1:0] ea_s3;
	logic [OAW-1:0] oa_s3;
	logic           sel_s3;
	logic [15:0]    frac_s3;
	logic           far_s3;

	assign pos      = PW'(p_s2[42:0]) * PW'(3 * EXP_TABLE_ENTRIES);
	assign idx_full = pos[PW-1:44];

	always_comb begin
		if (idx_full >= IFW'(EXP_TABLE_ENTRIES)) begin
			idx_c  = IW'(EXP_TABLE_ENTRIES - 1);
			frac_c = 16'hFFFF;
		end else begin
			idx_c  = idx_full[IW-1:0];
			frac_c = pos[43:28];
		end
	end

	assign idx_p1  = {1'b0, idx_c} + (IW+1)'(1);
	assign ea_full = idx_p1[IW:1];
	assign oa_full = idx_c >> 1;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			red_s3   <= red_s2;
			grn_s3   <= grn_s2;
			blu_s3   <= blu_s2;
			tamt_s3  <= tamt_s2;
			apply_s3 <= apply_s2;
			far_s3   <= p_s2 >= P_LIMIT;
			ea_s3    <= ea_full[EAW-1:0];
			oa_s3    <= oa_full[OAW-1:0];
			sel_s3   <= idx_c[0];
			frac_s3  <= frac_c;
		end
	end

	// stage 4: table read
	logic [24:0] even_s4;
	logic [24:0] odd_s4;
	logic        sel_s4;
	logic [15:0] frac_s4;
	logic        far_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			red_s4   <= red_s3;
			grn_s4   <= grn_s3;
			blu_s4   <= blu_s3;
			tamt_s4  <= tamt_s3;
			apply_s4 <= apply_s3;
			far_s4   <= far_s3;
			sel_s4   <= sel_s3;
			frac_s4  <= frac_s3;
			even_s4  <= rom_even[ea_s3];
			odd_s4   <= rom_odd[oa_s3];
		end
	end

	// stage 5: neighbor difference times fraction
	logic [24:0] lo;
	logic [24:0] hi;
	logic        down;
	logic [24:0] dlt;
	logic [40:0] prod_s5;
	logic [24:0] lo_s5;
	logic        down_s5;
	logic        far_s5;

	assign lo   = sel_s4 ? odd_s4 : even_s4;
	assign hi   = sel_s4 ? even_s4 : odd_s4;
	assign down = lo >= hi;
	assign dlt  = down ? (lo - hi) : (hi - lo);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			red_s5   <= red_s4;
			grn_s5   <= grn_s4;
			blu_s5   <= blu_s4;
			tamt_s5  <= tamt_s4;
			apply_s5 <= apply_s4;
			far_s5   <= far_s4;
			lo_s5    <= lo;
			down_s5  <= down;
			prod_s5  <= 41'(dlt) * 41'(frac_s4);
		end
	end

	// stage 6: interpolated exp and weight
	logic [25:0] e_val;
	logic [24:0] w_next;
	logic [24:0] w_s6;

	assign e_val = down_s5 ? ({1'b0, lo_s5} - {1'b0, prod_s5[40:16]})
		: ({1'b0, lo_s5} + {1'b0, prod_s5[40:16]});

	always_comb begin
		if (far_s5) begin
			w_next = ONE24;
		end else if (e_val >= {1'b0, ONE24}) begin
			w_next = '0;
		end else begin
			w_next = ONE24 - e_val[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			red_s6   <= red_s5;
			grn_s6   <= grn_s5;
			blu_s6   <= blu_s5;
			tamt_s6  <= tamt_s5;
			apply_s6 <= apply_s5;
			w_s6     <= w_next;
		end
	end

	// stage 7: blend factor
	logic [42:0] wa;
	logic [16:0] t_next;
	logic [16:0] t_s7;

	assign wa = 43'(w_s6) * 43'(amt) + 43'(1 << 23);

	always_comb begin
		if (!apply_s6) begin
			t_next = '0;
		end else if (tamt_s6) begin
			t_next = amt;
		end else begin
			t_next = wa[40:24];
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			red_s7 <= red_s6;
			grn_s7 <= grn_s6;
			blu_s7 <= blu_s6;
			t_s7   <= t_next;
		end
	end

	// stage 8: channel products
	logic [16:0]    inv_t;
	logic [PRW-1:0] red_a_s8, red_b_s8;
	logic [PRW-1:0] grn_a_s8, grn_b_s8;
	logic [PRW-1:0] blu_a_s8, blu_b_s8;

	assign inv_t = AMOUNT_ONE - t_s7;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			red_a_s8 <= PRW'(inv_t) * PRW'(red_s7);
			red_b_s8 <= PRW'(t_s7) * PRW'(mist_red_q);
			grn_a_s8 <= PRW'(inv_t) * PRW'(grn_s7);
			grn_b_s8 <= PRW'(t_s7) * PRW'(mist_green_q);
			blu_a_s8 <= PRW'(inv_t) * PRW'(blu_s7);
			blu_b_s8 <= PRW'(t_s7) * PRW'(mist_blue_q);
		end
	end

	// stage 9: round and output register
	logic [PRW:0] red_sum;
	logic [PRW:0] grn_sum;
	logic [PRW:0] blu_sum;

	assign red_sum = {1'b0, red_a_s8} + {1'b0, red_b_s8} + (PRW+1)'(32768);
	assign grn_sum = {1'b0, grn_a_s8} + {1'b0, grn_b_s8} + (PRW+1)'(32768);
	assign blu_sum = {1'b0, blu_a_s8} + {1'b0, blu_b_s8} + (PRW+1)'(32768);

	always_ff @(posedge clk) begin
		if (en[9]) begin
			out_red   <= red_sum[16 +: CW];
			out_green <= grn_sum[16 +: CW];
			out_blue  <= blu_sum[16 +: CW];
		end
	end

	// checks
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld))
		else $error("input stalled with an empty stage");

	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld[8] && !en[9] |=> vld[8] && $stable(red_a_s8))
		else $error("stage 8 item lost under stall");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[6] |-> w_s6 <= ONE24)
		else $error("weight above one");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[7] |-> t_s7 <= AMOUNT_ONE)
		else $error("blend factor above one");

	a_bank_addr: assert property (@(posedge clk) disable iff (!arst_n)
		vld[3] |-> (EAW + 1)'(oa_s3) + (EAW + 1)'(sel_s3) == (EAW + 1)'(ea_s3))
		else $error("even and odd bank addresses disagree");

endmodule

FILE: sim/depth_mist_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_mist_blend_tb
// Streams pixels through the mist blender with random idle cycles on the
// input and random stall on the output. A local fixed-point model builds its
// own exp table and predicts each blended colour. Results are compared in
// order, field by field. Directed pixels cover mask, background, start and
// far-depth cases. Random phases then sweep the register settings.
// ----------------------------------------------------------------------------
module depth_mist_blend_tb;
	import dmb_pkg::*;

	localparam int          CH_W        = 24;
	localparam int          TABLE_N     = 1024;
	localparam logic [63:0] Q32_ONE     = 64'd1 << 32;
	localparam logic [63:0] Q24_ONE     = 64'd1 << 24;
	localparam logic [63:0] AMOUNT_FULL = 64'd65536;
	localparam logic [63:0] FAR_P       = ((64'd16 << 40) + 64'd2) / 64'd3;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} color_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [31:0]     depth;
		logic            inf;
		logic            mask;
	} pixel_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_write;
	logic [2:0]      cfg_index;
	logic [31:0]     cfg_data;
	logic            in_valid;
	logic            in_stall;
	logic [CH_W-1:0] pixel_red;
	logic [CH_W-1:0] pixel_green;
	logic [CH_W-1:0] pixel_blue;
	logic [31:0]     depth;
	logic            depth_infinite;
	logic            mask_set;
	logic            out_valid;
	logic            out_stall;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;

	logic [CH_W-1:0] fog_red;
	logic [CH_W-1:0] fog_green;
	logic [CH_W-1:0] fog_blue;
	logic [16:0]     fog_amount;
	logic [31:0]     fog_start;
	logic [31:0]     fog_inv_range;
	logic            fog_skip_bg;

	logic [24:0]     exp_rom [0:TABLE_N];
	color_t          blended_q [$];
	int              fail_count;
	bit              fast_mode [0:1];

	depth_mist_blend dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_red      (pixel_red),
		.pixel_green    (pixel_green),
		.pixel_blue     (pixel_blue),
		.depth          (depth),
		.depth_infinite (depth_infinite),
		.mask_set       (mask_set),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_red        (out_red),
		.out_green      (out_green),
		.out_blue       (out_blue)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
		if (a >= Q32_ONE) begin
			return b;
		end
		if (b >= Q32_ONE) begin
			return a;
		end
		return (a * b + (Q32_ONE >> 1)) >> 32;
	endfunction

	// truncated taylor series of exp(-f), f in q0.32
	function automatic logic [63:0] exp_neg_q32(input logic [63:0] f);
		logic [63:0] acc;
		logic [63:0] term;
		acc  = Q32_ONE;
		term = Q32_ONE;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * f) >> 32) / 64'(k);
			acc  = (k % 2 == 1) ? acc - term : acc + term;
		end
		return acc;
	endfunction

	task automatic build_exp_rom();
		logic [63:0] e_one;
		logic [63:0] acc;
		logic [63:0] num;
		e_one = mul_q32(exp_neg_q32(Q32_ONE >> 1), exp_neg_q32(Q32_ONE >> 1));
		for (int k = 0; k <= TABLE_N; k++) begin
			num = 64'd16 * 64'(k);
			acc = Q32_ONE;
			for (int i = 0; i < int'(num / TABLE_N); i++) begin
				acc = mul_q32(acc, e_one);
			end
			acc = mul_q32(acc, exp_neg_q32(((num % TABLE_N) << 32) / TABLE_N));
			exp_rom[k] = 25'((acc + 64'd128) >> 8);
		end
	endtask

	function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b, input logic [63:0] t);
		logic [63:0] s;
		s = ((AMOUNT_FULL - t) * a + t * b + 64'd32768) >> 16;
		return s[CH_W-1:0];
	endfunction

	function automatic color_t blend_pixel(input pixel_t px);
		logic [63:0] amt;
		logic [63:0] t;
		logic [63:0] p;
		logic [63:0] w;
		logic [63:0] pos;
		logic [63:0] idx;
		logic [63:0] frac;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] e;
		logic        apply;
		color_t      res;
		amt   = (64'(fog_amount) > AMOUNT_FULL) ? AMOUNT_FULL : 64'(fog_amount);
		t     = 64'd0;
		apply = 1'b0;
		if (px.mask) begin
			if (px.inf) begin
				if (!fog_skip_bg) begin
					t     = amt;
					apply = 1'b1;
				end
			end else if (px.depth > fog_start) begin
				p = (64'(px.depth) - 64'(fog_start)) * 64'(fog_inv_range);
				if (p >= FAR_P) begin
					w = Q24_ONE;
				end else begin
					pos  = (64'd3 * p) * TABLE_N;
					idx  = pos >> 44;
					frac = (pos >> 28) & 64'hFFFF;
					if (idx >= TABLE_N) begin
						idx  = TABLE_N - 1;
						frac = 64'hFFFF;
					end
					lo = 64'(exp_rom[idx]);
					hi = 64'(exp_rom[idx + 1]);
					e  = (lo >= hi) ? lo - (((lo - hi) * frac) >> 16)
					                : lo + (((hi - lo) * frac) >> 16);
					w  = (e >= Q24_ONE) ? 64'd0 : Q24_ONE - e;
				end
				t     = (w * amt + (Q24_ONE >> 1)) >> 24;
				apply = 1'b1;
			end
		end
		if (apply) begin
			res.red   = mix_channel(px.red, fog_red, t);
			res.green = mix_channel(px.green, fog_green, t);
			res.blue  = mix_channel(px.blue, fog_blue, t);
		end else begin
			res.red   = px.red;
			res.green = px.green;
			res.blue  = px.blue;
		end
		return res;
	endfunction

	function automatic pixel_t make_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b, input logic [31:0] d, input logic inf, input logic mask);
		pixel_t px;
		px.red   = r;
		px.green = g;
		px.blue  = b;
		px.depth = d;
		px.inf   = inf;
		px.mask  = mask;
		return px;
	endfunction

	function automatic logic [CH_W-1:0] rand_channel();
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(0, 1) ? {CH_W{1'b1}} : {CH_W{1'b0}};
		end
		return CH_W'($urandom);
	endfunction

	// idle cycles before the next item; runs of zero come and go
	function automatic int draw_wait(input int side);
		if ($urandom_range(0, 39) == 0) begin
			fast_mode[side] = !fast_mode[side];
		end
		if (fast_mode[side]) begin
			return 0;
		end
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 3);
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t      px;
		int          sel;
		logic [63:0] tp;
		logic [63:0] delta;
		px = make_pixel(rand_channel(), rand_channel(), rand_channel(), $urandom, 1'b0,
			$urandom_range(0, 9) != 0);
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			px.inf = 1'b1;
		end else if (sel < 20) begin
			px.depth = $urandom;
		end else if (sel < 32) begin
			px.depth = fog_start >> $urandom_range(0, 8);
		end else begin
			// aim into the table range and a little past the far limit
			tp = {$urandom, $urandom} % (FAR_P + (FAR_P >> 2));
			if ($urandom_range(0, 2) == 0) begin
				tp = tp >> $urandom_range(1, 16);
			end
			delta = (fog_inv_range == 32'd0) ? 64'($urandom) : tp / 64'(fog_inv_range);
			if (delta == 64'd0) begin
				delta = 64'd1;
			end
			px.depth = (delta > 64'hFFFF_FFFF - 64'(fog_start)) ? 32'hFFFF_FFFF
			                                                   : 32'(64'(fog_start) + delta);
		end
		return px;
	endfunction

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [CH_W-1:0] got,
			input logic [CH_W-1:0] want);
		if (got !== want) begin
			report($sformatf("%s got %h expected %h", name, got, want));
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_MIST_RED:      fog_red       = value[CH_W-1:0];
			CFG_MIST_GREEN:    fog_green     = value[CH_W-1:0];
			CFG_MIST_BLUE:     fog_blue      = value[CH_W-1:0];
			CFG_MIST_AMOUNT:   fog_amount    = value[16:0];
			CFG_START_DEPTH:   fog_start     = value;
			CFG_INVERSE_RANGE: fog_inv_range = value;
			CFG_EXCLUDE_BG:    fog_skip_bg   = value[0];
			default: ;
		endcase
	endtask

	task automatic send_pixel(input pixel_t px);
		int gap;
		gap = draw_wait(0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_red      <= px.red;
		pixel_green    <= px.green;
		pixel_blue     <= px.blue;
		depth          <= px.depth;
		depth_infinite <= px.inf;
		mask_set       <= px.mask;
		in_valid       <= 1'b1;
		do @(posedge clk); while (!(in_valid && !in_stall));
		blended_q.push_back(blend_pixel(px));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (blended_q.size() != 0);
	endtask

	task automatic test_reset_values();
		send_pixel(make_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_pixel(make_pixel(24'h000000, 24'h000000, 24'h000000, 32'h0, 1'b1, 1'b1));
		send_pixel(make_pixel(24'h123456, 24'hABCDEF, 24'h00FF00, 32'h0, 1'b0, 1'b1));
		send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 24'h800000, 32'hFFFF_FFFF, 1'b0, 1'b1));
		send_pixel(make_pixel(24'h040000, 24'h020000, 24'h010000, 32'h0001_0000, 1'b0, 1'b1));
	endtask

	task automatic test_special_cases();
		drain();
		write_reg(CFG_MIST_RED, 32'h00_0000);
		write_reg(CFG_MIST_GREEN, 32'hFF_FFFF);
		write_reg(CFG_MIST_BLUE, 32'h12_3456);
		write_reg(CFG_MIST_AMOUNT, 32'h1_FFFF);
		write_reg(CFG_START_DEPTH, 32'h0010_0000);
		write_reg(CFG_INVERSE_RANGE, 32'hFFFF_FFFF);
		write_reg(CFG_EXCLUDE_BG, 32'd1);
		// excluded background, depth at start, just past start, far
		send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 24'h555555, 32'h0, 1'b1, 1'b1));
		send_pixel(make_pixel(24'hAAAAAA, 24'h555555, 24'hFFFFFF, 32'h0010_0000, 1'b0, 1'b1));
		send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 24'h000000, 32'h0010_0001, 1'b0, 1'b1));
		send_pixel(make_pixel(24'h800000, 24'h800000, 24'h800000, 32'h0010_0AAA, 1'b0, 1'b1));
		send_pixel(make_pixel(24'h000000, 24'hFFFFFF, 24'h000000, 32'hFFFF_FFFF, 1'b0, 1'b1));
		drain();
		write_reg(CFG_INVERSE_RANGE, 32'h0);
		send_pixel(make_pixel(24'h3C3C3C, 24'hC3C3C3, 24'h0F0F0F, 32'hFFFF_FFFF, 1'b0, 1'b1));
		drain();
		// table end against the far limit, inverse range of one
		write_reg(CFG_START_DEPTH, 32'h0);
		write_reg(CFG_INVERSE_RANGE, 32'h0100_0000);
		write_reg(CFG_MIST_AMOUNT, 32'd0);
		write_reg(CFG_EXCLUDE_BG, 32'd0);
		send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 32'h0005_5555, 1'b0, 1'b1));
		send_pixel(make_pixel(24'h000000, 24'hFFFFFF, 24'h000000, 32'h0005_5556, 1'b0, 1'b1));
		send_pixel(make_pixel(24'h777777, 24'h888888, 24'h999999, 32'h0, 1'b1, 1'b1));
		drain();
		write_reg(CFG_MIST_AMOUNT, 32'd32768);
		send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 32'h0000_8000, 1'b0, 1'b1));
		send_pixel(make_pixel(24'h000000, 24'hFFFFFF, 24'h000000, 32'h0001_8000, 1'b1, 1'b1));
		drain();
		write_reg(CFG_MIST_AMOUNT, 32'd65536);
		write_reg(CFG_START_DEPTH, 32'hFFFF_FFFF);
		send_pixel(make_pixel(24'h112233, 24'h445566, 24'h778899, 32'hFFFF_FFFF, 1'b0, 1'b1));
		send_pixel(make_pixel(24'h112233, 24'h445566, 24'h778899, 32'hFFFF_FFFF, 1'b1, 1'b1));
		send_pixel(make_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h0, 1'b1, 1'b0));
	endtask

	task automatic test_random_traffic();
		logic [31:0] amount;
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case ($urandom_range(0, 4))
				0:       amount = 32'd0;
				1:       amount = 32'd65536;
				2:       amount = $urandom_range(65537, 131071);
				default: amount = $urandom_range(0, 65536);
			endcase
			if (ph == 1) begin
				write_reg(CFG_MIST_RED, 32'hFF_FFFF);
				write_reg(CFG_MIST_GREEN, 32'h0);
				write_reg(CFG_MIST_BLUE, 32'hFF_FFFF);
				write_reg(CFG_MIST_AMOUNT, 32'h1_FFFF);
				write_reg(CFG_START_DEPTH, 32'h0);
				write_reg(CFG_INVERSE_RANGE, 32'hFFFF_FFFF);
				write_reg(CFG_EXCLUDE_BG, 32'd1);
			end else if (ph == 2) begin
				write_reg(CFG_MIST_RED, 32'h0);
				write_reg(CFG_MIST_GREEN, 32'hFF_FFFF);
				write_reg(CFG_MIST_BLUE, 32'h0);
				write_reg(CFG_MIST_AMOUNT, 32'd0);
				write_reg(CFG_START_DEPTH, 32'hFFFF_0000);
				write_reg(CFG_INVERSE_RANGE, 32'd1);
				write_reg(CFG_EXCLUDE_BG, 32'd0);
			end else begin
				write_reg(CFG_MIST_RED, 32'(rand_channel()));
				write_reg(CFG_MIST_GREEN, 32'(rand_channel()));
				write_reg(CFG_MIST_BLUE, 32'(rand_channel()));
				write_reg(CFG_MIST_AMOUNT, amount);
				write_reg(CFG_START_DEPTH,
					($urandom_range(0, 5) == 0) ? 32'h0 : $urandom >> $urandom_range(0, 31));
				write_reg(CFG_INVERSE_RANGE,
					($urandom_range(0, 7) == 0) ? 32'h0 : $urandom >> $urandom_range(0, 31));
				write_reg(CFG_EXCLUDE_BG, $urandom_range(0, 1));
			end
			repeat (220) send_pixel(random_pixel());
		end
	endtask

	// output side: random stall, then compare each item in order
	initial begin
		color_t want;
		int     hold;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_wait(1);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			if (blended_q.size() == 0) begin
				report($sformatf("unexpected item %h %h %h", out_red, out_green, out_blue));
			end else begin
				want = blended_q.pop_front();
				check_field("out_red", out_red, want.red);
				check_field("out_green", out_green, want.green);
				check_field("out_blue", out_blue, want.blue);
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_write      <= 1'b0;
		cfg_index      <= CFG_MIST_RED;
		cfg_data       <= 32'd0;
		in_valid       <= 1'b0;
		pixel_red      <= '0;
		pixel_green    <= '0;
		pixel_blue     <= '0;
		depth          <= 32'd0;
		depth_infinite <= 1'b0;
		mask_set       <= 1'b0;
		fail_count    = 0;
		fast_mode[0]  = 1'b0;
		fast_mode[1]  = 1'b0;
		fog_red       = 24'd65536;
		fog_green     = 24'd65536;
		fog_blue      = 24'd65536;
		fog_amount    = 17'd65536;
		fog_start     = 32'd0;
		fog_inv_range = 32'd16777;
		fog_skip_bg   = 1'b0;
		build_exp_rom();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_special_cases();
		test_random_traffic();
		drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("[depth_mist_blend] OK");
		end else begin
			$display("[depth_mist_blend] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[depth_mist_blend] ERROR");
		$finish;
	end

endmodule
